// ===== rtl/sst_pkg.sv =====
// Shared types and constants for the session token table.
package sst_pkg;

    localparam int TTL_W   = 31;
    localparam int TIME_W  = 32;
    localparam int TOKEN_W = 64;
    localparam int ENTRY_W = 2 * TOKEN_W + TIME_W;

    localparam logic [TTL_W-1:0] TTL_RESET = 31'd1800000;

    localparam logic [2:0] REQ_ISSUE    = 3'd0;
    localparam logic [2:0] REQ_VALIDATE = 3'd1;
    localparam logic [2:0] REQ_REVOKE   = 3'd2;
    localparam logic [2:0] REQ_QUERY    = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [TIME_W-1:0]  now_ms;
        logic [TOKEN_W-1:0] token_high;
        logic [TOKEN_W-1:0] token_low;
        logic               token_empty;
        logic               user_matches;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] slot_index;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic rd_en;
        logic wr_en;
        logic clr_used;
        logic clr_all;
        logic respond;
        logic resp_ok;
        logic resp_idx;
    } cmd_t;

    typedef struct packed {
        logic kind_issue;
        logic kind_lookup;
        logic kind_clear;
        logic op_validate;
        logic op_revoke;
        logic used_cur;
        logic expired;
        logic match;
        logic last;
    } stat_t;

endpackage

// ===== rtl/sst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/sst_ctrl.sv =====
// Request sequencer: walks the slots and issues datapath commands.
module sst_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sst_pkg::stat_t stat,
    output sst_pkg::cmd_t  cmd
);
    import sst_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_READ   = 5'b00100,
        S_CHECK  = 5'b01000,
        S_WRITE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.kind_issue || stat.kind_lookup)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    cmd.clr_all = stat.kind_clear;
                    cmd.respond = 1'b1;
                    cmd.resp_ok = stat.kind_clear;
                    state_next  = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.kind_issue)
                begin
                    if (!stat.used_cur || stat.expired)
                    begin
                        state_next = S_WRITE;
                    end
                    else if (stat.last)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_WRITE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_READ;
                    end
                end
                else if (stat.used_cur && !stat.expired && stat.match)
                begin
                    if (stat.op_validate)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        cmd.clr_used = stat.op_revoke;
                        cmd.respond  = 1'b1;
                        cmd.resp_ok  = 1'b1;
                        cmd.resp_idx = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    // drop a stale entry on the way past
                    cmd.clr_used = stat.used_cur && stat.expired;
                    if (stat.last)
                    begin
                        cmd.respond = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            S_WRITE:
            begin
                cmd.wr_en    = 1'b1;
                cmd.respond  = 1'b1;
                cmd.resp_ok  = 1'b1;
                cmd.resp_idx = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sst_datapath.sv =====
// Slot storage, request register, slot compare and result register.
module sst_datapath #(
    parameter int SESSION_SLOTS = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sst_pkg::req_t              req,
    input  logic                       cfg_we,
    input  logic [sst_pkg::TTL_W-1:0]  cfg_wdata,
    input  sst_pkg::cmd_t              cmd,
    output sst_pkg::stat_t             stat,
    output logic                       done,
    output sst_pkg::rsp_t              rsp
);
    import sst_pkg::*;

    localparam int IDX_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SESSION_SLOTS - 1);

    req_t                 req_reg;
    logic [TTL_W-1:0]     ttl_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [SESSION_SLOTS-1:0] used_reg;
    logic                 done_reg;
    rsp_t                 rsp_reg;

    logic [ENTRY_W-1:0]   rd_entry;
    logic [ENTRY_W-1:0]   wr_entry;
    logic [TIME_W-1:0]    new_expiry;
    logic [TIME_W-1:0]    diff;
    logic [IDX_W+1:0]     idx_ext;

    assign new_expiry = req_reg.now_ms + {1'b0, ttl_reg};
    assign wr_entry   = {req_reg.token_high, req_reg.token_low, new_expiry};
    assign diff       = rd_entry[TIME_W-1:0] - req_reg.now_ms;
    assign idx_ext    = {2'b00, idx_reg};

    sst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SESSION_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (idx_reg),
        .wdata (wr_entry),
        .re    (cmd.rd_en),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    always_comb
    begin
        stat.kind_issue  = (req_reg.req_type == REQ_ISSUE) && req_reg.user_matches
                           && !req_reg.token_empty;
        stat.kind_lookup = ((req_reg.req_type == REQ_VALIDATE)
                           || (req_reg.req_type == REQ_REVOKE)
                           || (req_reg.req_type == REQ_QUERY)) && !req_reg.token_empty;
        stat.kind_clear  = (req_reg.req_type == REQ_CLEAR);
        stat.op_validate = (req_reg.req_type == REQ_VALIDATE);
        stat.op_revoke   = (req_reg.req_type == REQ_REVOKE);
        stat.used_cur    = used_reg[idx_reg];
        stat.expired     = (diff == '0) || diff[TIME_W-1];
        stat.match       = (rd_entry[ENTRY_W-1 -: TOKEN_W] == req_reg.token_high)
                           && (rd_entry[TIME_W +: TOKEN_W] == req_reg.token_low);
        stat.last        = (idx_reg == LAST_IDX);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.respond)
        begin
            rsp_reg.ok         <= cmd.resp_ok;
            rsp_reg.slot_index <= (cmd.resp_ok && cmd.resp_idx) ? idx_ext[1:0] : 2'b00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg  <= TTL_RESET;
            idx_reg  <= '0;
            used_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ttl_reg <= cfg_wdata;
            end
            if (cmd.load || cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.clr_all)
            begin
                used_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                used_reg[idx_reg] <= 1'b1;
            end
            else if (cmd.clr_used)
            begin
                used_reg[idx_reg] <= 1'b0;
            end
            done_reg <= cmd.respond;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== rtl/session_token_table.sv =====
// Top level of the session token table.
//
// Channels: a request beat on req is taken at a clock edge where start is
// high and busy is low. Each request gives exactly one response beat on rsp,
// marked by done for one cycle; the receiver cannot stall it, so it must
// take the beat in that cycle. The TTL register is written through cfg_we
// and cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce. Clear all, an empty token, an issue
// for another user and an unknown code are answered from the decode state
// with no slot scan. An issue writes the first free or expired slot, or
// slot 0 when the table is full; a query or revoke hit answers from the
// check state, a validate hit rewrites the slot first, and a lookup miss
// answers after the last slot. The slot scan passes through the read and
// check states for each slot, as the read port of the entry RAM is
// registered. One request is in work at a time; busy drops in the cycle
// that done is shown, so the next request can start there.
// Reset empties the table at once through the per-slot used bits and loads
// the TTL with its default; no clearing pass is needed.
module session_token_table #(
    parameter int SESSION_SLOTS = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  sst_pkg::req_t             req,
    output logic                      done,
    output sst_pkg::rsp_t             rsp,
    input  logic                      cfg_we,
    input  logic [sst_pkg::TTL_W-1:0] cfg_wdata
);
    import sst_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    sst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    sst_datapath #(
        .SESSION_SLOTS (SESSION_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/sst_checker.sv =====
// Port-level checks for the session token table, bound to the top level.
module sst_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input sst_pkg::rsp_t rsp
);
    import sst_pkg::*;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response beat while still busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("response one cycle after accept");

    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.ok) |-> (rsp.slot_index == 2'b00))
        else $error("failed response carries a slot");

endmodule

bind session_token_table sst_checker u_sst_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
